// ----- rtl/ltobs_pkg.sv -----
// Types, constants and microcode program shared by the load torque observer.
// Used by every module of the block; depends on nothing.
package ltobs_pkg;

    // Number formats
    localparam int WORD_BITS     = 48;              // register, input and estimate width
    localparam int STEP_BITS     = WORD_BITS - 1;   // sample period is unsigned
    localparam int ACC_BITS      = 64;              // accumulators and products
    localparam int HALF_BITS     = ACC_BITS / 2;    // one multiplier operand
    localparam int PROD_BITS     = 2 * ACC_BITS;    // full product
    localparam int FRAC_BITS_DEF = 24;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;

    // Beat payloads
    typedef struct packed {
        logic signed [WORD_BITS-1:0] meas_speed;
        logic signed [WORD_BITS-1:0] drive_torque;
    } ltobs_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] speed_estimate;
        logic signed [WORD_BITS-1:0] load_estimate;
    } ltobs_out_t;

    // Configuration registers
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SPEED_DAMPING = 3'd0,
        REG_LOAD_COUPLING = 3'd1,
        REG_LOAD_SELF     = 3'd2,
        REG_TORQUE_GAIN   = 3'd3,
        REG_SPEED_WEIGHT  = 3'd4,
        REG_SPEED_GAIN    = 3'd5,
        REG_LOAD_GAIN     = 3'd6,
        REG_STEP_TIME     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        word_t                speed_damping;
        word_t                load_coupling;
        word_t                load_self;
        word_t                torque_gain;
        word_t                speed_weight;
        word_t                speed_gain;
        word_t                load_gain;
        logic [STEP_BITS-1:0] step_time;
    } ltobs_cfg_t;

    localparam word_t                RST_SPEED_WEIGHT = WORD_BITS'(64'sd16777216);
    localparam word_t                RST_SPEED_GAIN   = WORD_BITS'(64'sd16777216000);
    localparam word_t                RST_LOAD_GAIN    = WORD_BITS'(-64'sd4194304000);
    localparam logic [STEP_BITS-1:0] RST_STEP_TIME    = STEP_BITS'(839);

    // Multiplier operand and result routing
    typedef enum logic [3:0] {
        ASEL_SPEED_WEIGHT,
        ASEL_SPEED_DAMPING,
        ASEL_LOAD_COUPLING,
        ASEL_TORQUE_GAIN,
        ASEL_SPEED_GAIN,
        ASEL_LOAD_SELF,
        ASEL_LOAD_GAIN,
        ASEL_SPEED_ACC,
        ASEL_LOAD_ACC
    } asel_t;

    typedef enum logic [2:0] {
        BSEL_SPEED_HOLD,
        BSEL_LOAD_HOLD,
        BSEL_TORQUE,
        BSEL_ERR,
        BSEL_STEP
    } bsel_t;

    typedef enum logic [2:0] {
        DST_ERR,
        DST_SPEED_ACC,
        DST_LOAD_ACC,
        DST_SPEED_HOLD,
        DST_LOAD_HOLD
    } dst_t;

    typedef struct packed {
        asel_t a_sel;
        bsel_t b_sel;
        dst_t  dst;
    } term_t;

    localparam int NUM_TERMS  = 9;
    localparam int TERM_IDX_W = $clog2(NUM_TERMS);

    // One product per term, in the order the observer update needs them
    function automatic term_t term_lookup(logic [TERM_IDX_W-1:0] k);
        term_t t;
        case (k)
            4'd0:    t = '{ASEL_SPEED_WEIGHT,  BSEL_SPEED_HOLD, DST_ERR};
            4'd1:    t = '{ASEL_SPEED_DAMPING, BSEL_SPEED_HOLD, DST_SPEED_ACC};
            4'd2:    t = '{ASEL_LOAD_COUPLING, BSEL_LOAD_HOLD,  DST_SPEED_ACC};
            4'd3:    t = '{ASEL_TORQUE_GAIN,   BSEL_TORQUE,     DST_SPEED_ACC};
            4'd4:    t = '{ASEL_SPEED_GAIN,    BSEL_ERR,        DST_SPEED_ACC};
            4'd5:    t = '{ASEL_LOAD_SELF,     BSEL_LOAD_HOLD,  DST_LOAD_ACC};
            4'd6:    t = '{ASEL_LOAD_GAIN,     BSEL_ERR,        DST_LOAD_ACC};
            4'd7:    t = '{ASEL_SPEED_ACC,     BSEL_STEP,       DST_SPEED_HOLD};
            4'd8:    t = '{ASEL_LOAD_ACC,      BSEL_STEP,       DST_LOAD_HOLD};
            default: t = '{ASEL_SPEED_WEIGHT,  BSEL_SPEED_HOLD, DST_ERR};
        endcase
        return t;
    endfunction

    // Microcode
    typedef enum logic [2:0] {
        UOP_IDLE,   // wait for an input beat
        UOP_LOAD,   // latch operand magnitudes and product sign
        UOP_PART,   // one 32x32 partial product into the product sum
        UOP_FIN,    // sign, scale and saturate the product
        UOP_ACC,    // fold the product into its destination
        UOP_OUT     // hand the estimates to the output register
    } uop_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_MORE_TERMS,
        COND_OUT_BUSY
    } cond_t;

    localparam int PC_W = 4;

    typedef struct packed {
        uop_t            op;
        logic [1:0]      part;   // [1]: upper half of a, [0]: upper half of b
        cond_t           cond;
        logic [PC_W-1:0] br;     // target when the condition holds
        logic [PC_W-1:0] nx;     // target otherwise
    } ucode_t;

    function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{UOP_IDLE, 2'd0, COND_NO_INPUT,   4'd0, 4'd1};
            4'd1:    w = '{UOP_LOAD, 2'd0, COND_NONE,       4'd0, 4'd2};
            4'd2:    w = '{UOP_PART, 2'd0, COND_NONE,       4'd0, 4'd3};
            4'd3:    w = '{UOP_PART, 2'd1, COND_NONE,       4'd0, 4'd4};
            4'd4:    w = '{UOP_PART, 2'd2, COND_NONE,       4'd0, 4'd5};
            4'd5:    w = '{UOP_PART, 2'd3, COND_NONE,       4'd0, 4'd6};
            4'd6:    w = '{UOP_FIN,  2'd0, COND_NONE,       4'd0, 4'd7};
            4'd7:    w = '{UOP_ACC,  2'd0, COND_MORE_TERMS, 4'd1, 4'd8};
            4'd8:    w = '{UOP_OUT,  2'd0, COND_OUT_BUSY,   4'd8, 4'd0};
            default: w = '{UOP_IDLE, 2'd0, COND_NO_INPUT,   4'd0, 4'd1};
        endcase
        return w;
    endfunction

    // Sequencer to datapath control, and status back
    typedef struct packed {
        uop_t       op;
        logic [1:0] part;
        term_t      term;
    } ltobs_ctl_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } ltobs_stat_t;

endpackage

// ----- rtl/ltobs_seq.sv -----
// Microcode sequencer: step counter, program ROM and term counter.
// Depends on ltobs_pkg.
module ltobs_seq
    import ltobs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ltobs_stat_t stat,
    output ltobs_ctl_t  ctl
);

    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [TERM_IDX_W-1:0] term_reg, term_next;
    ucode_t                uw;
    logic                  take_br;

    assign uw = ucode_rom(pc_reg);

    // Branch condition
    always_comb begin
        case (uw.cond)
            COND_NONE:       take_br = 1'b0;
            COND_NO_INPUT:   take_br = !stat.in_valid;
            COND_MORE_TERMS: take_br = (term_reg != TERM_IDX_W'(NUM_TERMS - 1));
            COND_OUT_BUSY:   take_br = stat.out_busy;
            default:         take_br = 1'b0;
        endcase
    end

    // Next step and term index
    always_comb begin
        pc_next   = take_br ? uw.br : uw.nx;
        term_next = term_reg;
        if (uw.op == UOP_IDLE) begin
            term_next = '0;
        end else if (uw.op == UOP_ACC) begin
            term_next = term_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            term_reg <= '0;
        end else begin
            pc_reg   <= pc_next;
            term_reg <= term_next;
        end
    end

    assign ctl.op   = uw.op;
    assign ctl.part = uw.part;
    assign ctl.term = term_lookup(term_reg);

endmodule

// ----- rtl/ltobs_mul.sv -----
// Shared fixed-point multiplier: 64x64 signed product built from four 32x32
// partial products, then floor-scaled by FRAC_BITS and saturated to 64 bits.
// Depends on ltobs_pkg.
module ltobs_mul
    import ltobs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  ltobs_ctl_t ctl,
    input  acc_t       a_op,
    input  acc_t       b_op,
    output acc_t       prod
);

    localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic [ACC_BITS-1:0]  mag_a_reg, mag_b_reg;
    logic                 neg_reg;
    logic [PROD_BITS-1:0] sum_reg;
    acc_t                 prod_reg;

    logic [HALF_BITS-1:0] a_half, b_half;
    logic [ACC_BITS-1:0]  pp;
    logic [PROD_BITS-1:0] addend;
    logic [PROD_BITS-1:0] prod_s;
    logic [PROD_BITS-1:0] scaled;
    logic                 fits;
    acc_t                 fin_val;

    // Partial product of the selected halves
    assign a_half = ctl.part[1] ? mag_a_reg[ACC_BITS-1:HALF_BITS] : mag_a_reg[HALF_BITS-1:0];
    assign b_half = ctl.part[0] ? mag_b_reg[ACC_BITS-1:HALF_BITS] : mag_b_reg[HALF_BITS-1:0];
    assign pp     = {{HALF_BITS{1'b0}}, a_half} * {{HALF_BITS{1'b0}}, b_half};

    always_comb begin
        case (ctl.part)
            2'd0:    addend = {{ACC_BITS{1'b0}}, pp};
            2'd3:    addend = {pp, {ACC_BITS{1'b0}}};
            default: addend = {{HALF_BITS{1'b0}}, pp, {HALF_BITS{1'b0}}};
        endcase
    end

    // Signed product, floor shift, saturation to 64 bits
    assign prod_s  = neg_reg ? (PROD_BITS'(0) - sum_reg) : sum_reg;
    assign scaled  = PROD_BITS'($signed(prod_s) >>> FRAC_BITS);
    assign fits    = (scaled[PROD_BITS-1:ACC_BITS-1] == '0) ||
                     (scaled[PROD_BITS-1:ACC_BITS-1] == '1);
    assign fin_val = fits ? acc_t'(scaled[ACC_BITS-1:0])
                          : (prod_s[PROD_BITS-1] ? ACC_MIN : ACC_MAX);

    always_ff @(posedge aclk) begin
        case (ctl.op)
            UOP_LOAD: begin
                mag_a_reg <= a_op[ACC_BITS-1] ? ACC_BITS'(-a_op) : ACC_BITS'(a_op);
                mag_b_reg <= b_op[ACC_BITS-1] ? ACC_BITS'(-b_op) : ACC_BITS'(b_op);
                neg_reg   <= a_op[ACC_BITS-1] ^ b_op[ACC_BITS-1];
                sum_reg   <= '0;
            end
            UOP_PART: begin
                sum_reg <= sum_reg + addend;
            end
            UOP_FIN: begin
                prod_reg <= fin_val;
            end
            default: begin
            end
        endcase
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/ltobs_dp.sv -----
// Observer datapath: operand selection, speed error, saturating accumulators
// and estimate holds. Depends on ltobs_pkg.
module ltobs_dp
    import ltobs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ltobs_ctl_t ctl,
    input  ltobs_cfg_t cfg,
    input  ltobs_in_t  in_beat,
    input  acc_t       prod,
    output acc_t       a_op,
    output acc_t       b_op,
    output word_t      speed_hold,
    output word_t      load_hold
);

    localparam int   EXT_BITS = ACC_BITS - WORD_BITS;
    localparam acc_t ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam acc_t ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    function automatic acc_t sext(word_t v);
        return {{EXT_BITS{v[WORD_BITS-1]}}, v};
    endfunction

    function automatic acc_t sat_add(acc_t a, acc_t b);
        acc_t s;
        s = a + b;
        if (a[ACC_BITS-1] == b[ACC_BITS-1] && s[ACC_BITS-1] != a[ACC_BITS-1]) begin
            return a[ACC_BITS-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    function automatic acc_t sat_sub(acc_t a, acc_t b);
        acc_t s;
        s = a - b;
        if (a[ACC_BITS-1] != b[ACC_BITS-1] && s[ACC_BITS-1] != a[ACC_BITS-1]) begin
            return a[ACC_BITS-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    function automatic word_t sat_word(acc_t v);
        if (v[ACC_BITS-1:WORD_BITS-1] == '0 || v[ACC_BITS-1:WORD_BITS-1] == '1) begin
            return v[WORD_BITS-1:0];
        end
        return v[ACC_BITS-1] ? WORD_MIN : WORD_MAX;
    endfunction

    acc_t  speed_acc_reg, speed_acc_next;
    acc_t  load_acc_reg,  load_acc_next;
    word_t speed_hold_reg, speed_hold_next;
    word_t load_hold_reg,  load_hold_next;
    acc_t  err_reg;

    // Operand A: gains, matrix entries and accumulators
    always_comb begin
        case (ctl.term.a_sel)
            ASEL_SPEED_WEIGHT:  a_op = sext(cfg.speed_weight);
            ASEL_SPEED_DAMPING: a_op = sext(cfg.speed_damping);
            ASEL_LOAD_COUPLING: a_op = sext(cfg.load_coupling);
            ASEL_TORQUE_GAIN:   a_op = sext(cfg.torque_gain);
            ASEL_SPEED_GAIN:    a_op = sext(cfg.speed_gain);
            ASEL_LOAD_SELF:     a_op = sext(cfg.load_self);
            ASEL_LOAD_GAIN:     a_op = sext(cfg.load_gain);
            ASEL_SPEED_ACC:     a_op = speed_acc_reg;
            ASEL_LOAD_ACC:      a_op = load_acc_reg;
            default:            a_op = '0;
        endcase
    end

    // Operand B: held estimates, torque, error, step time
    always_comb begin
        case (ctl.term.b_sel)
            BSEL_SPEED_HOLD: b_op = sext(speed_hold_reg);
            BSEL_LOAD_HOLD:  b_op = sext(load_hold_reg);
            BSEL_TORQUE:     b_op = sext(in_beat.drive_torque);
            BSEL_ERR:        b_op = err_reg;
            BSEL_STEP:       b_op = {{(ACC_BITS-STEP_BITS){1'b0}}, cfg.step_time};
            default:         b_op = '0;
        endcase
    end

    // Fold the finished product into its destination
    always_comb begin
        speed_acc_next  = speed_acc_reg;
        load_acc_next   = load_acc_reg;
        speed_hold_next = speed_hold_reg;
        load_hold_next  = load_hold_reg;
        if (ctl.op == UOP_ACC) begin
            case (ctl.term.dst)
                DST_SPEED_ACC:  speed_acc_next  = sat_add(speed_acc_reg, prod);
                DST_LOAD_ACC:   load_acc_next   = sat_add(load_acc_reg, prod);
                DST_SPEED_HOLD: speed_hold_next = sat_word(prod);
                DST_LOAD_HOLD:  load_hold_next  = sat_word(prod);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_acc_reg  <= '0;
            load_acc_reg   <= '0;
            speed_hold_reg <= '0;
            load_hold_reg  <= '0;
        end else begin
            speed_acc_reg  <= speed_acc_next;
            load_acc_reg   <= load_acc_next;
            speed_hold_reg <= speed_hold_next;
            load_hold_reg  <= load_hold_next;
        end
    end

    // Speed error against the weighted previous estimate
    always_ff @(posedge aclk) begin
        if (ctl.op == UOP_ACC && ctl.term.dst == DST_ERR) begin
            err_reg <= sat_sub(sext(in_beat.meas_speed), prod);
        end
    end

    assign speed_hold = speed_hold_reg;
    assign load_hold  = load_hold_reg;

endmodule

// ----- rtl/load_torque_observer.sv -----
// Channel   Dir  Handshake           Beat
// s_        in   s_valid / s_ready   ltobs_in_t  {meas_speed, drive_torque}
// m_        out  m_valid / m_ready   ltobs_out_t {speed_estimate, load_estimate}
// cfg_      in   cfg_we              cfg_idx selects register, cfg_wdata value
//
// Each input beat is accepted in the idle step; nine products then follow in turn
// on the shared 32x32 multiplier, each a load step, four partial products, a finish
// step and a fold step, and a last step loads the output register.
// Reset is synchronous and active low; it restores the register defaults and
// clears both accumulators and both estimate holds. No clearing pass.
// A new input beat is taken while a result waits in the output register; the
// sequencer then stalls at its output step until m_ready drains that result.
// Top level: configuration registers, input capture, output register.
// Depends on ltobs_pkg, ltobs_seq, ltobs_mul and ltobs_dp.
module load_torque_observer
    import ltobs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ltobs_in_t            s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ltobs_out_t           m_data,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_idx,
    input  logic [WORD_BITS-1:0] cfg_wdata
);

    ltobs_cfg_t  cfg_reg;
    ltobs_in_t   in_reg;
    ltobs_out_t  out_reg;
    logic        out_valid_reg;
    ltobs_ctl_t  ctl;
    ltobs_stat_t stat;
    acc_t        a_op, b_op, prod;
    word_t       speed_hold, load_hold;
    logic        out_busy;
    logic        in_take;

    assign out_busy      = out_valid_reg && !m_ready;
    assign in_take       = s_valid && s_ready;
    assign stat.in_valid = s_valid;
    assign stat.out_busy = out_busy;
    assign s_ready       = (ctl.op == UOP_IDLE);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_damping <= '0;
            cfg_reg.load_coupling <= '0;
            cfg_reg.load_self     <= '0;
            cfg_reg.torque_gain   <= '0;
            cfg_reg.speed_weight  <= RST_SPEED_WEIGHT;
            cfg_reg.speed_gain    <= RST_SPEED_GAIN;
            cfg_reg.load_gain     <= RST_LOAD_GAIN;
            cfg_reg.step_time     <= RST_STEP_TIME;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_idx))
                REG_SPEED_DAMPING: cfg_reg.speed_damping <= cfg_wdata;
                REG_LOAD_COUPLING: cfg_reg.load_coupling <= cfg_wdata;
                REG_LOAD_SELF:     cfg_reg.load_self     <= cfg_wdata;
                REG_TORQUE_GAIN:   cfg_reg.torque_gain   <= cfg_wdata;
                REG_SPEED_WEIGHT:  cfg_reg.speed_weight  <= cfg_wdata;
                REG_SPEED_GAIN:    cfg_reg.speed_gain    <= cfg_wdata;
                REG_LOAD_GAIN:     cfg_reg.load_gain     <= cfg_wdata;
                REG_STEP_TIME:     cfg_reg.step_time     <= cfg_wdata[STEP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input beat capture
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_reg <= s_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.op == UOP_OUT && !out_busy) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == UOP_OUT && !out_busy) begin
            out_reg.speed_estimate <= speed_hold;
            out_reg.load_estimate  <= load_hold;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    ltobs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    ltobs_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .aclk (aclk),
        .ctl  (ctl),
        .a_op (a_op),
        .b_op (b_op),
        .prod (prod)
    );

    ltobs_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .cfg        (cfg_reg),
        .in_beat    (in_reg),
        .prod       (prod),
        .a_op       (a_op),
        .b_op       (b_op),
        .speed_hold (speed_hold),
        .load_hold  (load_hold)
    );

endmodule

// ----- rtl/ltobs_checker.sv -----
// Port-level checks for the load torque observer, bound to the top level.
// Depends on ltobs_pkg and load_torque_observer.
module ltobs_checker
    import ltobs_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input ltobs_out_t m_data
);

    // Beats taken but not yet delivered
    logic [1:0] pend_reg, pend_next;

    always_comb begin
        pend_next = pend_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            pend_next = pend_reg + 1'b1;
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One beat at a time in the sequencer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken back to back");

    // Every delivered result belongs to an accepted beat
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> pend_reg != 2'd0)
        else $error("result without a pending input");

    // At most one result waits when a new beat is taken
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> pend_reg == 2'd0 || pend_reg == 2'd1)
        else $error("input taken with two results pending");

endmodule

bind load_torque_observer ltobs_checker u_ltobs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- verif/tb_load_torque_observer.sv -----
// Self-checking testbench for the load torque observer: directed and random beats, checked
// field by field against a bit-exact Q24.24 observer model kept in the bench.
// Depends on rtl/ltobs_pkg.sv and rtl/load_torque_observer.sv.
module tb_load_torque_observer
    import ltobs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CLK_PERIOD      = 10;
    localparam int   RESET_CYCLES    = 9;
    localparam int   NUM_REGS        = 2 ** REG_IDX_W;
    localparam int   PHASES          = 12;
    localparam int   BEATS_PER_PHASE = 158;
    localparam int   SETTLE_CYCLES   = 80;     // longer than one beat takes to process
    localparam int   STALL_LIMIT     = 5000;   // cycles with no beat on either side
    localparam int   FRAC            = FRAC_BITS_DEF;
    localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam acc_t  A_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam acc_t  A_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    // How a random word is drawn
    typedef enum int {VAL_FULL, VAL_SCALED, VAL_EDGE, VAL_MIXED} val_style_t;
    // Receiver back-pressure patterns
    typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    ltobs_in_t            s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    ltobs_out_t           m_data;
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_idx   = '0;
    logic [WORD_BITS-1:0] cfg_wdata = '0;

    // Observer model state
    ltobs_cfg_t obs_cfg;
    acc_t       obs_speed_acc;
    acc_t       obs_load_acc;
    word_t      obs_speed_hold;
    word_t      obs_load_hold;

    ltobs_out_t           estimate_q[$];
    logic [WORD_BITS-1:0] reg_image[NUM_REGS];
    int                   mismatches   = 0;
    int                   stall_cycles = 0;
    int                   rx_cycle     = 0;
    rx_mode_t             rx_mode      = RX_ALWAYS;

    load_torque_observer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    // ---------------- fixed-point arithmetic ----------------

    function automatic acc_t widen(word_t w);
        return {{(ACC_BITS-WORD_BITS){w[WORD_BITS-1]}}, w};
    endfunction

    // floor(a * b / 2^FRAC), clamped to 64-bit signed
    function automatic acc_t q_mul(acc_t a, acc_t b);
        logic signed [PROD_BITS-1:0] wa;
        logic signed [PROD_BITS-1:0] wb;
        logic signed [PROD_BITS-1:0] p;
        wa = a;
        wb = b;
        p  = (wa * wb) >>> FRAC;
        if (p[PROD_BITS-1:ACC_BITS-1] != {(PROD_BITS-ACC_BITS+1){p[PROD_BITS-1]}})
            return p[PROD_BITS-1] ? A_MIN : A_MAX;
        return p[ACC_BITS-1:0];
    endfunction

    function automatic acc_t acc_add(acc_t a, acc_t b);
        logic [ACC_BITS:0] s;
        s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        if (s[ACC_BITS] != s[ACC_BITS-1])
            return s[ACC_BITS] ? A_MIN : A_MAX;
        return s[ACC_BITS-1:0];
    endfunction

    function automatic acc_t acc_sub(acc_t a, acc_t b);
        logic [ACC_BITS:0] s;
        s = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
        if (s[ACC_BITS] != s[ACC_BITS-1])
            return s[ACC_BITS] ? A_MIN : A_MAX;
        return s[ACC_BITS-1:0];
    endfunction

    function automatic word_t word_sat(acc_t v);
        if (v[ACC_BITS-1:WORD_BITS-1] != {(ACC_BITS-WORD_BITS+1){v[WORD_BITS-1]}})
            return v[ACC_BITS-1] ? W_MIN : W_MAX;
        return v[WORD_BITS-1:0];
    endfunction

    // ---------------- observer model ----------------

    function automatic void reset_observer_model();
        obs_cfg               = '0;
        obs_cfg.speed_weight  = RST_SPEED_WEIGHT;
        obs_cfg.speed_gain    = RST_SPEED_GAIN;
        obs_cfg.load_gain     = RST_LOAD_GAIN;
        obs_cfg.step_time     = RST_STEP_TIME;
        obs_speed_acc         = '0;
        obs_load_acc          = '0;
        obs_speed_hold        = '0;
        obs_load_hold         = '0;
    endfunction

    // One observer update; both terms use the holds from the previous sample
    function automatic ltobs_out_t advance_observer(ltobs_in_t d);
        acc_t       x0;
        acc_t       x1;
        acc_t       err;
        acc_t       step;
        ltobs_out_t r;
        x0   = widen(obs_speed_hold);
        x1   = widen(obs_load_hold);
        step = {{(ACC_BITS-STEP_BITS){1'b0}}, obs_cfg.step_time};
        err  = acc_sub(widen(d.meas_speed), q_mul(widen(obs_cfg.speed_weight), x0));

        obs_speed_acc = acc_add(obs_speed_acc, q_mul(widen(obs_cfg.speed_damping), x0));
        obs_speed_acc = acc_add(obs_speed_acc, q_mul(widen(obs_cfg.load_coupling), x1));
        obs_speed_acc = acc_add(obs_speed_acc,
                                q_mul(widen(obs_cfg.torque_gain), widen(d.drive_torque)));
        obs_speed_acc = acc_add(obs_speed_acc, q_mul(widen(obs_cfg.speed_gain), err));

        obs_load_acc  = acc_add(obs_load_acc, q_mul(widen(obs_cfg.load_self), x1));
        obs_load_acc  = acc_add(obs_load_acc, q_mul(widen(obs_cfg.load_gain), err));

        obs_speed_hold = word_sat(q_mul(obs_speed_acc, step));
        obs_load_hold  = word_sat(q_mul(obs_load_acc, step));

        r.speed_estimate = obs_speed_hold;
        r.load_estimate  = obs_load_hold;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic word_t rand_value(val_style_t style);
        logic [63:0] r;
        int          k;
        val_style_t  pick;
        pick = style;
        if (pick == VAL_MIXED) begin
            k = $urandom_range(0, 9);
            pick = (k < 6) ? VAL_SCALED : ((k < 8) ? VAL_FULL : VAL_EDGE);
        end
        r = {$urandom(), $urandom()};
        case (pick)
            VAL_FULL: begin
                return r[WORD_BITS-1:0];
            end
            VAL_SCALED: begin
                k = $urandom_range(0, 40);
                r = r & ((64'd1 << k) - 64'd1);
                if ($urandom_range(0, 1) == 1) r = -r;
                return r[WORD_BITS-1:0];
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       return W_MAX;
                    1:       return W_MIN;
                    2:       return '0;
                    3:       return word_t'(1);
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Write all registers from reg_image back to back; the block must be idle
    task automatic program_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= reg_idx_t'(i);
            cfg_wdata <= reg_image[i];
            case (reg_idx_t'(i))
                REG_SPEED_DAMPING: obs_cfg.speed_damping = reg_image[i];
                REG_LOAD_COUPLING: obs_cfg.load_coupling = reg_image[i];
                REG_LOAD_SELF:     obs_cfg.load_self     = reg_image[i];
                REG_TORQUE_GAIN:   obs_cfg.torque_gain   = reg_image[i];
                REG_SPEED_WEIGHT:  obs_cfg.speed_weight  = reg_image[i];
                REG_SPEED_GAIN:    obs_cfg.speed_gain    = reg_image[i];
                REG_LOAD_GAIN:     obs_cfg.load_gain     = reg_image[i];
                REG_STEP_TIME:     obs_cfg.step_time     = reg_image[i][STEP_BITS-1:0];
                default: ;
            endcase
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Present one beat and hold it until taken; valid stays high on return
    task automatic send_beat(input word_t speed, input word_t torque);
        ltobs_in_t d;
        d.meas_speed   = speed;
        d.drive_torque = torque;
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (s_ready !== 1'b1);
        estimate_q.push_back(advance_observer(d));
    endtask

    task automatic sender_gap(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Stop sending and wait for every outstanding estimate
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (estimate_q.size() != 0);
    endtask

    // ---------------- tests ----------------

    // Register defaults straight out of reset, input fields at their limits
    task automatic test_reset_defaults();
        send_beat('0, '0);
        send_beat(W_MAX, '0);
        send_beat(W_MIN, '0);
        send_beat('0, W_MAX);
        send_beat('0, W_MIN);
        send_beat(W_MAX, W_MAX);
        hold_until_drained();
    endtask

    // Full-scale registers drive accumulators and estimates into saturation
    task automatic test_saturation_extremes();
        foreach (reg_image[i]) reg_image[i] = W_MAX;
        program_regs();
        send_beat(W_MAX, W_MAX);
        send_beat(W_MAX, W_MAX);
        send_beat(W_MIN, W_MIN);
        send_beat(W_MIN, W_MIN);
        send_beat(W_MIN, W_MIN);
        hold_until_drained();

        // most negative everywhere; step_time gets all ones, its top bit dropped
        foreach (reg_image[i]) reg_image[i] = W_MIN;
        reg_image[REG_STEP_TIME] = '1;
        program_regs();
        send_beat(W_MIN, W_MAX);
        send_beat(W_MAX, W_MIN);
        send_beat(W_MAX, W_MAX);
        hold_until_drained();
    endtask

    // Bit above the 47-bit step_time field must not reach the datapath
    task automatic test_step_time_upper_bit();
        foreach (reg_image[i]) reg_image[i] = rand_value(VAL_SCALED);
        reg_image[REG_SPEED_WEIGHT] = RST_SPEED_WEIGHT;
        reg_image[REG_STEP_TIME]    = {1'b1, STEP_BITS'(839)};
        program_regs();
        repeat (4) send_beat(rand_value(VAL_SCALED), rand_value(VAL_SCALED));
        hold_until_drained();
    endtask

    // Random settings per phase, bursty beats, one mid-phase drain
    task automatic test_random_traffic();
        val_style_t cfg_style;
        val_style_t in_style;
        bit         walk;
        word_t      speed;
        int         burst;
        int         drain_at;
        for (int phase = 0; phase < PHASES; phase++) begin
            hold_until_drained();
            if (phase == 0)
                cfg_style = VAL_SCALED;
            else if (phase == 1)
                cfg_style = VAL_EDGE;
            else
                cfg_style = val_style_t'($urandom_range(0, 3));
            foreach (reg_image[i]) reg_image[i] = rand_value(cfg_style);
            program_regs();

            in_style = val_style_t'($urandom_range(0, 3));
            walk     = ($urandom_range(0, 2) == 0);
            speed    = rand_value(VAL_SCALED);
            drain_at = $urandom_range(10, BEATS_PER_PHASE - 10);
            burst    = $urandom_range(1, 24);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n == drain_at)
                    hold_until_drained();
                // a random walk keeps the speed trace plausible for the observer
                speed = walk ? speed + (rand_value(VAL_SCALED) >>> 12) : rand_value(in_style);
                send_beat(speed, rand_value(in_style));
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0)
                        sender_gap($urandom_range(1, 90));
                end
            end
        end
    endtask

    // ---------------- result checking and receiver stalls ----------------

    always @(posedge aclk) begin : result_side
        ltobs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (estimate_q.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: %h", m_data));
            end else begin
                want = estimate_q.pop_front();
                if (m_data.speed_estimate !== want.speed_estimate)
                    report_mismatch($sformatf("speed_estimate got %0d expected %0d",
                                              m_data.speed_estimate, want.speed_estimate));
                if (m_data.load_estimate !== want.load_estimate)
                    report_mismatch($sformatf("load_estimate got %0d expected %0d",
                                              m_data.load_estimate, want.load_estimate));
            end
        end

        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 400 == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:   m_ready <= 1'b1;
            RX_COIN:     m_ready <= ($urandom_range(0, 1) == 1);
            RX_PERIODIC: m_ready <= ((rx_cycle % 7) < 4);
            default:     m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Watchdog: no beat on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_load_torque_observer failed");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        reset_observer_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_saturation_extremes();
        test_step_time_upper_bit();
        test_random_traffic();

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_load_torque_observer passed");
        else
            $display("tb_load_torque_observer failed");
        $finish;
    end

endmodule
